// File: rtl/cc20_pkg.sv
// Shared types, constants and helpers for the ChaCha20 stream cipher core.
package cc20_pkg;

  // Core sizing
  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int WORD_W            = 32;
  localparam int NUM_WORDS         = 16;
  localparam int DATA_W            = 64;
  localparam int CNT_W             = 4;
  localparam int TDATA_W           = 72;
  localparam int PAD_W             = TDATA_W - DATA_W - CNT_W;
  localparam int NUM_CFG           = 5;
  localparam int CFG_IDX_W         = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd4;

  // "expand 32-byte k"
  localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } state_t;

  // Rotate left by the amount of the given quarter-round step (16, 12, 8, 7)
  function automatic word_t qr_rotl(input word_t v, input logic [1:0] step);
    word_t r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage

// File: rtl/chacha20_stream_cipher_core.sv
// ChaCha20 stream cipher core: key/nonce registers, round sequencer and output register.
//
// Usage: load key words (index 0..3) and nonce (index 4) on the cfg_ write channel
// while the core is idle; writes to indexes 5..7 are dropped, cfg_ready is always high.
// Each in_ transaction carries 8 data bytes plus a 4-bit valid-byte count in in_tdata
// and an end-of-message flag on in_tlast. Each one yields exactly one out_ transaction:
// the data XORed with the next 8 keystream bytes, bytes at or above the count zeroed,
// count and tlast copied through.
// A word in the middle of a block is accepted while idle, then loads the output register
// from the emit state. The first word of a block first builds the 64-byte keystream block
// with one shared 32-bit adder doing one quarter-round step per cycle: DOUBLE_ROUNDS
// double rounds in the round state, then the final state addition in the feed state.
// in_tready is high only while the sequencer is idle; it stays high while a finished
// result waits in the output register. If out_tready is low the core holds the next
// result in the sequencer until the output register frees up.
// Reset (rst_n low, synchronous) clears the key, nonce, block counter and word
// position; the next word starts block 0. End of message discards the rest of the
// block, and the following message starts at the next block counter value.
module chacha20_stream_cipher_core #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cc20_pkg::TDATA_W-1:0]     in_tdata,   // data_in[63:0], bytes_valid_in[67:64], pad
  input  logic                             in_tlast,   // message_end_in
  // Output stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cc20_pkg::TDATA_W-1:0]     out_tdata,  // data_out[63:0], bytes_valid_out[67:64], pad
  output logic                             out_tlast,  // message_end_out
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cc20_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

  cc20_pkg::state_t state_r, state_nxt;

  logic [cc20_pkg::DATA_W-1:0] cfg_regs_r [cc20_pkg::NUM_CFG];
  cc20_pkg::word_t             x_r   [cc20_pkg::NUM_WORDS];
  cc20_pkg::word_t             x_nxt [cc20_pkg::NUM_WORDS];
  cc20_pkg::word_t             x_upd [cc20_pkg::NUM_WORDS];
  cc20_pkg::word_t             x_rot [cc20_pkg::NUM_WORDS];
  cc20_pkg::word_t             init_w [cc20_pkg::NUM_WORDS];
  logic [1:0]                  k_row [4];

  logic [cc20_pkg::DATA_W-1:0] ctr_r;
  logic [2:0]                  wp_r;
  logic [DR_W-1:0]             dr_r;
  logic [2:0]                  qr_r;
  logic [1:0]                  step_r;
  logic [3:0]                  ff_cnt_r;

  logic [cc20_pkg::DATA_W-1:0] data_r;
  logic [cc20_pkg::CNT_W-1:0]  cnt_r;
  logic                        end_r;

  logic                        out_valid_r;
  logic [cc20_pkg::DATA_W-1:0] out_data_r;
  logic [cc20_pkg::CNT_W-1:0]  out_cnt_r;
  logic                        out_end_r;

  cc20_pkg::word_t             op_a, op_b, sum;
  logic [cc20_pkg::DATA_W-1:0] ks_word, result;
  logic                        in_acc, emit_go, round_last, feed_last;

  assign in_acc     = in_tvalid && in_tready;
  assign round_last = (step_r == 2'd3) && (qr_r == 3'd7) && (dr_r == DR_LAST);
  assign feed_last  = (ff_cnt_r == 4'd15);
  assign cfg_ready  = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cc20_pkg::NUM_CFG; i++) cfg_regs_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cc20_pkg::REG_KEY0:  cfg_regs_r[0] <= cfg_data;
        cc20_pkg::REG_KEY1:  cfg_regs_r[1] <= cfg_data;
        cc20_pkg::REG_KEY2:  cfg_regs_r[2] <= cfg_data;
        cc20_pkg::REG_KEY3:  cfg_regs_r[3] <= cfg_data;
        cc20_pkg::REG_NONCE: cfg_regs_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Initial block state: constants, key, counter, nonce
  always_comb begin
    init_w[0]  = cc20_pkg::SIGMA0;
    init_w[1]  = cc20_pkg::SIGMA1;
    init_w[2]  = cc20_pkg::SIGMA2;
    init_w[3]  = cc20_pkg::SIGMA3;
    init_w[4]  = cfg_regs_r[cc20_pkg::REG_KEY0][31:0];
    init_w[5]  = cfg_regs_r[cc20_pkg::REG_KEY0][63:32];
    init_w[6]  = cfg_regs_r[cc20_pkg::REG_KEY1][31:0];
    init_w[7]  = cfg_regs_r[cc20_pkg::REG_KEY1][63:32];
    init_w[8]  = cfg_regs_r[cc20_pkg::REG_KEY2][31:0];
    init_w[9]  = cfg_regs_r[cc20_pkg::REG_KEY2][63:32];
    init_w[10] = cfg_regs_r[cc20_pkg::REG_KEY3][31:0];
    init_w[11] = cfg_regs_r[cc20_pkg::REG_KEY3][63:32];
    init_w[12] = ctr_r[31:0];
    init_w[13] = ctr_r[63:32];
    init_w[14] = cfg_regs_r[cc20_pkg::REG_NONCE][31:0];
    init_w[15] = cfg_regs_r[cc20_pkg::REG_NONCE][63:32];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cc20_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = (wp_r == 3'd0) ? cc20_pkg::ST_ROUND : cc20_pkg::ST_EMIT;
      end
      cc20_pkg::ST_ROUND: begin
        if (round_last) state_nxt = cc20_pkg::ST_FEED;
      end
      cc20_pkg::ST_FEED: begin
        if (feed_last) state_nxt = cc20_pkg::ST_EMIT;
      end
      cc20_pkg::ST_EMIT: begin
        if (emit_go) state_nxt = cc20_pkg::ST_IDLE;
      end
      default: state_nxt = cc20_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    emit_go   = 1'b0;
    unique case (state_r)
      cc20_pkg::ST_IDLE:  in_tready = 1'b1;
      cc20_pkg::ST_ROUND: ;
      cc20_pkg::ST_FEED:  ;
      cc20_pkg::ST_EMIT:  emit_go = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cc20_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Shared adder: quarter-round step or final feed-forward
  always_comb begin
    if (state_r == cc20_pkg::ST_FEED) begin
      op_a = x_r[0];
      op_b = init_w[ff_cnt_r];
    end else if (!step_r[0]) begin
      op_a = x_r[0];
      op_b = x_r[4];
    end else begin
      op_a = x_r[8];
      op_b = x_r[12];
    end
    sum = op_a + op_b;
  end

  // Quarter-round step on the fixed lanes a=0, b=4, c=8, d=12
  always_comb begin
    x_upd = x_r;
    if (!step_r[0]) begin
      x_upd[0]  = sum;
      x_upd[12] = cc20_pkg::qr_rotl(x_r[12] ^ sum, step_r);
    end else begin
      x_upd[8]  = sum;
      x_upd[4]  = cc20_pkg::qr_rotl(x_r[4] ^ sum, step_r);
    end
  end

  // Row rotation after each quarter round; the last one of a half round also
  // diagonalizes (after columns) or restores the row order (after diagonals)
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (step_r != 2'd3)     k_row[r] = 2'd0;
      else if (qr_r == 3'd3)  k_row[r] = 2'(r) + 2'd1;
      else if (qr_r == 3'd7)  k_row[r] = 2'd1 - 2'(r);
      else                    k_row[r] = 2'd1;
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        x_rot[4*r+j] = x_upd[{2'(r), 2'(j) + k_row[r]}];
      end
    end
  end

  // State word register update
  always_comb begin
    x_nxt = x_r;
    unique case (state_r)
      cc20_pkg::ST_IDLE: begin
        if (in_acc && (wp_r == 3'd0)) x_nxt = init_w;
      end
      cc20_pkg::ST_ROUND: x_nxt = x_rot;
      cc20_pkg::ST_FEED: begin
        for (int i = 0; i < cc20_pkg::NUM_WORDS - 1; i++) x_nxt[i] = x_r[i+1];
        x_nxt[cc20_pkg::NUM_WORDS-1] = sum;
      end
      cc20_pkg::ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  // Round and feed-forward counters, block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      qr_r     <= '0;
      dr_r     <= '0;
      ff_cnt_r <= '0;
      ctr_r    <= '0;
    end else begin
      if (state_r == cc20_pkg::ST_ROUND) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          qr_r <= qr_r + 3'd1;
          if (qr_r == 3'd7) dr_r <= round_last ? '0 : dr_r + DR_W'(1);
        end
      end
      if (state_r == cc20_pkg::ST_FEED) begin
        ff_cnt_r <= ff_cnt_r + 4'd1;
        if (feed_last) ctr_r <= ctr_r + 64'd1;
      end
    end
  end

  // Captured input transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r <= in_tdata[cc20_pkg::DATA_W-1:0];
      cnt_r  <= in_tdata[cc20_pkg::DATA_W +: cc20_pkg::CNT_W];
      end_r  <= in_tlast;
    end
  end

  // Keystream word select and byte masking
  always_comb begin
    ks_word = {x_r[{wp_r, 1'b1}], x_r[{wp_r, 1'b0}]};
    for (int b = 0; b < 8; b++) begin
      result[8*b +: 8] = (cnt_r > 4'(b)) ? (data_r[8*b +: 8] ^ ks_word[8*b +: 8]) : 8'h00;
    end
  end

  // Word position within the block
  always_ff @(posedge clk) begin
    if (!rst_n)       wp_r <= '0;
    else if (emit_go) wp_r <= end_r ? 3'd0 : wp_r + 3'd1;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (emit_go)    out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r <= result;
      out_cnt_r  <= cnt_r;
      out_end_r  <= end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{cc20_pkg::PAD_W{1'b0}}, out_cnt_r, out_data_r};
  assign out_tlast  = out_end_r;

  // Assertions
  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (wp_r == 3'd0)) |=>
      (state_r == cc20_pkg::ST_ROUND && step_r == 2'd0 && qr_r == 3'd0 && dr_r == '0))
    else $error("block generation did not start from a clean round count");

  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cc20_pkg::ST_FEED && feed_last) |=> (ctr_r == $past(ctr_r) + 64'd1))
    else $error("block counter did not advance after feed-forward");

  a_ctr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == cc20_pkg::ST_FEED && feed_last) |=> $stable(ctr_r))
    else $error("block counter moved outside feed-forward end");

  a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cc20_pkg::ST_EMIT) |=> $stable(wp_r))
    else $error("word position moved without an emitted result");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == cc20_pkg::ST_EMIT))
    else $error("output register loaded outside the emit state");

endmodule

// File: sim/tb.sv
// Self-checking testbench for chacha20_stream_cipher_core: keystream XOR over valid/ready streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DATA_W            = cc20_pkg::DATA_W;
  localparam int  CNT_W             = cc20_pkg::CNT_W;
  localparam int  TDATA_W           = cc20_pkg::TDATA_W;
  localparam int  PAD_W             = cc20_pkg::PAD_W;
  localparam int  CFG_IDX_W         = cc20_pkg::CFG_IDX_W;
  localparam int  NUM_CFG           = cc20_pkg::NUM_CFG;

  localparam int  ROUNDS            = cc20_pkg::DOUBLE_ROUNDS_DEF;
  localparam int  CLK_HALF          = 6;
  localparam int  RESET_CYCLES      = 10;
  localparam int  WORDS_PER_SETTING = 150;
  localparam int  LONG_HOLD_CYCLES  = 3000;
  localparam int  TAIL_CYCLES       = 400;
  localparam real TIMEOUT_NS        = 15.0e6;

  // "expand 32-byte k"
  localparam logic [31:0] EXPAND_0 = 32'h6170_7865;
  localparam logic [31:0] EXPAND_1 = 32'h3320_646e;
  localparam logic [31:0] EXPAND_2 = 32'h7962_2d32;
  localparam logic [31:0] EXPAND_3 = 32'h6b20_6574;

  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } cipher_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] want;
  } stim_row_t;

  // Directed words; the key and nonce are all zero after reset
  localparam int NUM_DIRECTED = 22;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // first keystream word of the all-zero key, block 0
    '{64'h0,                    4'd8,  1'b0, 1'b1, 64'h903d_f1a0_ade0_b876},
    '{ONES,                     4'd8,  1'b0, 1'b0, 64'h0},
    // partial byte counts; with no valid byte the output is zero, keystream word still used up
    '{64'h0123_4567_89ab_cdef,  4'd0,  1'b0, 1'b1, 64'h0},
    '{64'hfedc_ba98_7654_3210,  4'd1,  1'b0, 1'b0, 64'h0},
    '{64'ha5a5_a5a5_a5a5_a5a5,  4'd7,  1'b0, 1'b0, 64'h0},
    // counts above eight act as eight
    '{64'h5a5a_5a5a_5a5a_5a5a,  4'd15, 1'b0, 1'b0, 64'h0},
    '{64'h0f1e_2d3c_4b5a_6978,  4'd9,  1'b0, 1'b0, 64'h0},
    '{ONES,                     4'd8,  1'b0, 1'b0, 64'h0},
    // rolls into block 1 without a message end
    '{64'h1122_3344_5566_7788,  4'd8,  1'b0, 1'b0, 64'h0},
    '{ONES,                     4'd0,  1'b1, 1'b1, 64'h0},
    // single-word messages, each one a fresh block
    '{64'h0,                    4'd8,  1'b1, 1'b0, 64'h0},
    '{ONES,                     4'd8,  1'b1, 1'b0, 64'h0},
    // full block ending exactly on the eighth word
    '{64'h0,                    4'd8,  1'b0, 1'b0, 64'h0},
    '{ONES,                     4'd8,  1'b0, 1'b0, 64'h0},
    '{64'h8000_0000_0000_0001,  4'd8,  1'b0, 1'b0, 64'h0},
    '{64'h7fff_ffff_ffff_fffe,  4'd8,  1'b0, 1'b0, 64'h0},
    '{64'h0000_0000_ffff_ffff,  4'd8,  1'b0, 1'b0, 64'h0},
    '{64'hffff_ffff_0000_0000,  4'd8,  1'b0, 1'b0, 64'h0},
    '{64'h3c3c_c3c3_3c3c_c3c3,  4'd8,  1'b0, 1'b0, 64'h0},
    '{64'hc3c3_3c3c_c3c3_3c3c,  4'd8,  1'b1, 1'b0, 64'h0},
    '{64'h0bad_c0de_1234_5678,  4'd3,  1'b0, 1'b0, 64'h0},
    '{ONES,                     4'd12, 1'b1, 1'b0, 64'h0}
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DATA_W-1:0]    cfg_data   = '0;

  // Cipher state mirror
  logic [63:0] key_nonce [NUM_CFG];
  logic [63:0] blk_ctr;
  logic [63:0] ks_words [8];
  logic [2:0]  ks_pos;
  logic [31:0] mix_st [16];

  cipher_res_t expected_q [$];
  int          errors        = 0;
  bit          tx_idle       = 1'b1;
  bit          long_hold_req = 1'b0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  chacha20_stream_cipher_core #(
    .DOUBLE_ROUNDS(ROUNDS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter_round(input int a, input int b, input int c, input int d);
    mix_st[a] = mix_st[a] + mix_st[b]; mix_st[d] = rotl32(mix_st[d] ^ mix_st[a], 16);
    mix_st[c] = mix_st[c] + mix_st[d]; mix_st[b] = rotl32(mix_st[b] ^ mix_st[c], 12);
    mix_st[a] = mix_st[a] + mix_st[b]; mix_st[d] = rotl32(mix_st[d] ^ mix_st[a], 8);
    mix_st[c] = mix_st[c] + mix_st[d]; mix_st[b] = rotl32(mix_st[b] ^ mix_st[c], 7);
  endfunction

  // Build the next 64-byte keystream block and advance the block counter
  function automatic void next_keystream_block();
    logic [31:0] init_st [16];
    init_st[0] = EXPAND_0;
    init_st[1] = EXPAND_1;
    init_st[2] = EXPAND_2;
    init_st[3] = EXPAND_3;
    for (int i = 0; i < 4; i++) begin
      init_st[4 + 2 * i] = key_nonce[i][31:0];
      init_st[5 + 2 * i] = key_nonce[i][63:32];
    end
    init_st[12] = blk_ctr[31:0];
    init_st[13] = blk_ctr[63:32];
    init_st[14] = key_nonce[cc20_pkg::REG_NONCE][31:0];
    init_st[15] = key_nonce[cc20_pkg::REG_NONCE][63:32];
    for (int i = 0; i < 16; i++) mix_st[i] = init_st[i];
    for (int r = 0; r < ROUNDS; r++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (int i = 0; i < 8; i++) begin
      ks_words[i] = {mix_st[2 * i + 1] + init_st[2 * i + 1], mix_st[2 * i] + init_st[2 * i]};
    end
    blk_ctr = blk_ctr + 64'd1;
  endfunction

  function automatic cipher_res_t encrypt_word(input logic [63:0] d, input logic [3:0] cnt,
                                               input logic last);
    cipher_res_t res;
    logic [63:0] mask;
    if (ks_pos == 3'd0) next_keystream_block();
    mask = (cnt >= 4'd8) ? ONES : ((64'd1 << (8 * cnt)) - 64'd1);
    res.data = (d ^ ks_words[ks_pos]) & mask;
    res.cnt  = cnt;
    res.last = last;
    ks_pos   = last ? 3'd0 : ks_pos + 3'd1;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // One input transaction; the expectation is queued at acceptance
  task automatic send_word(input logic [63:0] d, input logic [3:0] cnt, input logic last,
                           input logic typed, input logic [63:0] want);
    int gap;
    cipher_res_t res;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, cnt, d};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    res = encrypt_word(d, cnt, last);
    if (typed) res.data = want;
    expected_q.push_back(res);
  endtask

  // Random message; mostly full words, a short tail, some malformed counts
  task automatic send_message(input int len);
    logic [3:0] cnt;
    logic       last;
    for (int w = 0; w < len; w++) begin
      last = (w == len - 1);
      if ($urandom_range(0, 9) == 0) cnt = 4'($urandom_range(0, 15));
      else if (last) cnt = 4'($urandom_range(1, 8));
      else cnt = 4'd8;
      send_word({$urandom(), $urandom()}, cnt, last, 1'b0, 64'h0);
    end
  endtask

  task automatic random_words();
    int n;
    int len;
    n = 0;
    while (n < WORDS_PER_SETTING) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      tx_idle = ($urandom_range(0, 4) != 0);
      send_message(len);
      n += len;
    end
  endtask

  // Stop offering and wait until every expected result is in
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_CFG) key_nonce[idx] = val;
  endtask

  // Key/nonce settings: all ones, random, mostly zero; unused indexes are hit too
  task automatic program_setting(input int sel);
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          val;
    for (int k = 0; k < NUM_CFG; k++) begin
      idx = CFG_IDX_W'(k);
      case (sel)
        1: val = ONES;
        2: val = {$urandom(), $urandom()};
        default: begin
          if (idx == cc20_pkg::REG_NONCE) val = {$urandom(), $urandom()};
          else if (idx == cc20_pkg::REG_KEY0) val = ONES;
          else val = 64'h0;
        end
      endcase
      write_reg(idx, val);
    end
    for (int k = NUM_CFG; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), {$urandom(), $urandom()});
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, quiet stretches, one long hold-off
  initial begin
    cipher_res_t want;
    int          stall;
    int          run_left;
    bit          quiet;
    run_left = 0;
    quiet    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (run_left == 0) begin
        run_left = $urandom_range(10, 60);
        quiet    = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_q.size() == 0) begin
        flag_mismatch("result with nothing expected", out_tdata[DATA_W-1:0], 64'h0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[DATA_W-1:0] !== want.data)
          flag_mismatch("data", out_tdata[DATA_W-1:0], want.data);
        if (out_tdata[DATA_W+CNT_W-1:DATA_W] !== want.cnt)
          flag_mismatch("byte count", 64'(out_tdata[DATA_W+CNT_W-1:DATA_W]), 64'(want.cnt));
        if (out_tlast !== want.last)
          flag_mismatch("message end", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  // Main sequence
  initial begin
    for (int i = 0; i < NUM_CFG; i++) key_nonce[i] = 64'h0;
    blk_ctr = 64'h0;
    ks_pos  = 3'd0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle = 1'b1;
    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].data, DIRECTED[i].cnt, DIRECTED[i].last,
                DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int sel = 0; sel < 4; sel++) begin
      if (sel > 0) begin
        drain();
        program_setting(sel);
      end
      if (sel == 2) long_hold_req = 1'b1;
      random_words();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cc20_pkg.sv
rtl/chacha20_stream_cipher_core.sv
sim/tb.sv
